>>> hdl/nlpd_pkg.sv
// Shared types, constants and the floor(30.6001 * x) month-term table for the lunar phase date pipeline.
package nlpd_pkg;

	// Input request and result payloads
	typedef struct packed {
		logic [11:0] in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
		logic [15:0] phase_goal;
	} req_t;

	typedef struct packed {
		logic [12:0] event_year;
		logic [3:0]  event_month;
		logic [4:0]  event_day;
	} result_t;

	// Integer Julian day number width and the day span of the folded phase difference
	localparam int JD_W   = 22;
	localparam int DAYS_W = 21;

	// Day number passed from the phase section to the calendar section
	typedef struct packed {
		logic            valid;
		logic [JD_W-1:0] z;
	} zday_t;

	// Synodic constant is split for the multipliers
	localparam int SYN_SPLIT = 24;

	// Whole synodic months folded into the epoch so the phase difference stays positive
	localparam int FOLD_MONTHS = 25000;

	// Reciprocal of the synodic month used to estimate the month count
	localparam int RECIP_SH = 24;
	localparam int RECIP_W  = 20;
	localparam int NEST_W   = 16;

	// 1524 less the constant 2 of the century correction
	localparam int JD_BIAS = 1522;

	// First day number of the Gregorian calendar
	localparam logic [JD_W-1:0] GREG_START = JD_W'(2299161);

	// Reciprocal constants: floor(v / D) = (v * K) >> SH over the range in use
	localparam int          DIV100_SH = 19;
	localparam logic [12:0] DIV100_K  = 13'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
	localparam int          DIV400_SH = 21;
	localparam logic [12:0] DIV400_K  = 13'(((64'd1 << DIV400_SH) + 64'd399) / 64'd400);
	localparam int          ALPHA_SH  = 41;
	localparam logic [23:0] ALPHA_K   = 24'(((64'd1 << ALPHA_SH) + 64'd146096) / 64'd146097);
	localparam int          CENT_SH   = 39;
	localparam logic [26:0] CENT_K    = 27'(((64'd1 << CENT_SH) + 64'd7304) / 64'd7305);
	// Month step: reciprocal of 306001 with the factor 10000 folded in
	localparam int          MON_SH    = 43;
	localparam logic [38:0] MON_KT    =
		39'((((64'd1 << MON_SH) + 64'd306000) / 64'd306001) * 64'd10000);

	// floor(30.6001 * x)
	function automatic logic [8:0] month_term(input logic [3:0] x);
		logic [8:0] r;
		case (x)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd30;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd91;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd183;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd244;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd336;
			4'd12:   r = 9'd367;
			4'd13:   r = 9'd397;
			4'd14:   r = 9'd428;
			4'd15:   r = 9'd459;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/nlpd_cal.sv
// Six-stage pipeline that turns an integer Julian day number into a calendar date.
module nlpd_cal (
	input  logic              clk,
	input  logic              arst_n,
	input  nlpd_pkg::zday_t   zin,
	output logic              done,
	output nlpd_pkg::result_t result
);

	localparam int JW = nlpd_pkg::JD_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [JW-1:0] z_s1;
	logic [5:0]    alpha_s1;
	logic          jul_s1;
	logic [JW-1:0] bb_s2;
	logic [JW-1:0] bb_s3;
	logic [13:0]   c_s3;
	logic [8:0]    t_s4;
	logic [13:0]   c_s4;
	logic [3:0]    e_s5;
	logic [8:0]    t_s5;
	logic [13:0]   c_s5;
	nlpd_pkg::result_t res_s6;

	logic [23:0]   zv_full;
	logic [46:0]   pa;
	logic [JW-1:0] bb;
	logic [25:0]   cv;
	logic [52:0]   pc;
	logic [23:0]   pd;
	logic [JW-1:0] tt;
	logic [47:0]   pe;
	logic [3:0]    mon;
	logic [8:0]    dsum;
	nlpd_pkg::result_t res;

	always_comb begin
		// alpha = (4z - 7468865) / 146097, used only on the Gregorian branch
		zv_full = 24'({zin.z, 2'b00}) - 24'd7468865;
		pa      = 47'(zv_full[22:0]) * 47'(nlpd_pkg::ALPHA_K);
	end

	always_comb begin
		if (jul_s1) begin
			bb = z_s1 + JW'(1524);
		end else begin
			bb = z_s1 + JW'(1525) + JW'(alpha_s1) - JW'(alpha_s1 >> 2);
		end
	end

	always_comb begin
		cv = 26'(bb_s2) * 26'd20 - 26'd2442;
		pc = 53'(cv) * 53'(nlpd_pkg::CENT_K);
	end

	always_comb begin
		pd = 24'(c_s3) * 24'd1461;
		tt = bb_s3 - JW'(pd[23:2]);
	end

	always_comb begin
		pe = 48'(t_s4) * 48'(nlpd_pkg::MON_KT);
	end

	always_comb begin
		mon  = (e_s5 < 4'd14) ? e_s5 - 4'd1 : e_s5 - 4'd13;
		dsum = t_s5 - nlpd_pkg::month_term(e_s5);
		res.event_month = mon;
		res.event_day   = dsum[4:0];
		res.event_year  = (mon > 4'd2) ? 13'(c_s5) - 13'd4716 : 13'(c_s5) - 13'd4715;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= zin.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		z_s1     <= zin.z;
		alpha_s1 <= pa[nlpd_pkg::ALPHA_SH +: 6];
		jul_s1   <= zin.z < nlpd_pkg::GREG_START;
		bb_s2    <= bb;
		bb_s3    <= bb_s2;
		c_s3     <= pc[nlpd_pkg::CENT_SH +: 14];
		t_s4     <= tt[8:0];
		c_s4     <= c_s3;
		e_s5     <= pe[nlpd_pkg::MON_SH +: 4];
		t_s5     <= t_s4;
		c_s5     <= c_s4;
		res_s6   <= res;
	end

	assign done   = v_s6;
	assign result = res_s6;

endmodule

>>> hdl/next_lunar_phase_date_core.sv
// Top level: date to mean-phase day number pipeline feeding the calendar conversion.
//
// Takes one request per clock and never asserts busy. Each request gives one result
// through seven stages from date to day number and phase span, then six stages back to
// a calendar date; done is high for a single cycle with each result, and results
// leave in request order. The receiver cannot hold results off, so it must capture
// result whenever done is high. The input is read as a Gregorian date; the result uses
// the Julian calendar before day number 2299161. Days are carried with FRAC_BITS
// fractional bits, and the result day is the whole day of the phase instant.
module next_lunar_phase_date_core #(
	parameter int FRAC_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  nlpd_pkg::req_t    req,
	output logic              done,
	output nlpd_pkg::result_t result
);

	localparam int JW     = nlpd_pkg::JD_W;
	localparam int SPL    = nlpd_pkg::SYN_SPLIT;
	localparam int NW     = nlpd_pkg::NEST_W;
	localparam int SynW   = FRAC_BITS + 5;
	localparam int SynHiW = SynW - SPL;
	localparam int SpanW  = SynW + 3;
	localparam int DiffW  = FRAC_BITS + nlpd_pkg::DAYS_W;
	localparam int TgW    = 16 + SynW;
	localparam int PnW    = nlpd_pkg::DAYS_W + nlpd_pkg::RECIP_W;

	// Synodic month and epoch, rounded to nearest in the fixed-point day scale
	localparam logic [127:0] SynX   =
		(((128'd29530588861) << (FRAC_BITS + 1)) / 128'd1000000000 + 128'd1) >> 1;
	localparam logic [127:0] EpochX =
		(((128'd24515501) << (FRAC_BITS + 1)) / 128'd10 + 128'd1) >> 1;
	// Epoch moved back by whole months, plus the half day of the 0h start
	localparam logic [127:0] C0X    = EpochX - SynX * 128'(nlpd_pkg::FOLD_MONTHS)
		+ (128'd1 << (FRAC_BITS - 1));
	localparam logic [127:0] CeilX  = (C0X + (128'd1 << FRAC_BITS) - 128'd1) >> FRAC_BITS;
	localparam logic [127:0] RecX   = (128'd1 << (nlpd_pkg::RECIP_SH + FRAC_BITS)) / SynX;

	localparam logic [SynW-1:0]              Syn      = SynX[SynW-1:0];
	localparam logic [SynHiW-1:0]            SynHi    = SynX[SynW-1:SPL];
	localparam logic [SPL-1:0]               SynLo    = SynX[SPL-1:0];
	localparam logic [SpanW-1:0]             Syn2     = SpanW'(SynX * 128'd2);
	localparam logic [DiffW-1:0]             C0       = C0X[DiffW-1:0];
	localparam logic [JW-1:0]                CeilDays = CeilX[JW-1:0];
	localparam logic [nlpd_pkg::RECIP_W-1:0] Recip    = RecX[nlpd_pkg::RECIP_W-1:0];

	logic accept;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1
	logic [5:0]            q100_s1;
	logic [3:0]            q400_s1;
	logic [13:0]           yp_s1;
	logic [8:0]            mt_s1;
	logic [4:0]            day_s1;
	logic [TgW-SPL-1:0]    tgh_s1;
	logic [16+SPL-1:0]     tgl_s1;
	// stage 2
	logic [JW-1:0]         jint_s2;
	logic [SynW-1:0]       target_s2;
	// stage 3
	logic [JW-1:0]         jint_s3;
	logic [DiffW-1:0]      diff_s3;
	logic [NW-1:0]         nest_s3;
	logic [SpanW-1:0]      tp0_s3, tp1_s3, tp2_s3;
	// stage 4
	logic [JW-1:0]         jint_s4;
	logic [DiffW-1:0]      diff_s4;
	logic [NW+SynHiW-1:0]  ph_s4;
	logic [NW+SPL-1:0]     pl_s4;
	logic [SpanW-1:0]      tp0_s4, tp1_s4, tp2_s4;
	// stage 5
	logic [JW-1:0]         jint_s5;
	logic [SynW:0]         rem_s5;
	logic [SpanW-1:0]      tp0_s5, tp1_s5, tp2_s5;
	// stage 6
	logic [JW-1:0]         jint_s6;
	logic [4:0]            sint_s6;
	// stage 7
	logic [JW-1:0]         z_s7;

	// stage 1 logic
	logic [3:0]   mcl;
	logic [3:0]   midx;
	logic         adj;
	logic [12:0]  y100, y400;
	logic [13:0]  yp;
	logic [25:0]  p100, p400;
	// stage 2 logic
	logic [24:0]  p1461;
	logic [23:0]  jsum;
	logic [TgW-1:0] tfull;
	// stage 3 logic
	logic [JW-1:0]  days;
	logic [PnW-1:0] pn;
	// stage 5 logic
	logic [DiffW-1:0] rsum;
	// stage 6 logic
	logic           big;
	logic [SpanW-1:0] d0, d1, d2, span;

	nlpd_pkg::zday_t zd;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_comb begin
		mcl = req.in_month;
		if (mcl == 4'd0) begin
			mcl = 4'd1;
		end else if (mcl > 4'd12) begin
			mcl = 4'd12;
		end
		// January and February count as months 13 and 14 of the year before
		adj  = mcl <= 4'd2;
		midx = adj ? mcl + 4'd13 : mcl + 4'd1;
		// offset the year so the century quotients are taken of a non-negative value
		y100 = 13'(req.in_year) + 13'd100 - 13'(adj);
		y400 = 13'(req.in_year) + 13'd400 - 13'(adj);
		yp   = 14'(req.in_year) + 14'd4716 - 14'(adj);
		p100 = 26'(y100) * 26'(nlpd_pkg::DIV100_K);
		p400 = 26'(y400) * 26'(nlpd_pkg::DIV400_K);
	end

	always_comb begin
		p1461 = 25'(yp_s1) * 25'd1461;
		// century correction: 2 - floor(y/100) + floor(y/400), quotients held one high
		jsum  = 24'(p1461[24:2]) + 24'(mt_s1) + 24'(day_s1) + 24'(q400_s1)
			- 24'(q100_s1) - 24'(nlpd_pkg::JD_BIAS);
		tfull = TgW'({tgh_s1, {SPL{1'b0}}}) + TgW'(tgl_s1);
	end

	always_comb begin
		// month count estimate; it reads low by at most one
		days = jint_s2 - CeilDays;
		pn   = PnW'(days[nlpd_pkg::DAYS_W-1:0]) * PnW'(Recip);
	end

	always_comb begin
		rsum = diff_s4 - DiffW'({ph_s4, {SPL{1'b0}}}) - DiffW'(pl_s4);
	end

	always_comb begin
		// remainder lies below two months; fold the extra month and the wrap into one pick
		big = rem_s5 >= (SynW + 1)'(Syn);
		d0  = tp0_s5 - SpanW'(rem_s5);
		d1  = tp1_s5 - SpanW'(rem_s5);
		d2  = tp2_s5 - SpanW'(rem_s5);
		if (big) begin
			span = (!d1[SpanW-1] && d1 != '0) ? d1 : d2;
		end else begin
			span = (!d0[SpanW-1] && d0 != '0) ? d0 : d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		q100_s1   <= p100[nlpd_pkg::DIV100_SH +: 6];
		q400_s1   <= p400[nlpd_pkg::DIV400_SH +: 4];
		yp_s1     <= yp;
		mt_s1     <= nlpd_pkg::month_term(midx);
		day_s1    <= req.in_day;
		tgh_s1    <= (TgW - SPL)'(req.phase_goal) * (TgW - SPL)'(SynHi);
		tgl_s1    <= (16 + SPL)'(req.phase_goal) * (16 + SPL)'(SynLo);

		jint_s2   <= jsum[JW-1:0];
		target_s2 <= tfull[16 +: SynW];

		jint_s3   <= jint_s2;
		diff_s3   <= DiffW'({jint_s2, {FRAC_BITS{1'b0}}}) - C0;
		nest_s3   <= pn[nlpd_pkg::RECIP_SH +: NW];
		tp0_s3    <= SpanW'(target_s2);
		tp1_s3    <= SpanW'(target_s2) + SpanW'(Syn);
		tp2_s3    <= SpanW'(target_s2) + Syn2;

		jint_s4   <= jint_s3;
		diff_s4   <= diff_s3;
		ph_s4     <= (NW + SynHiW)'(nest_s3) * (NW + SynHiW)'(SynHi);
		pl_s4     <= (NW + SPL)'(nest_s3) * (NW + SPL)'(SynLo);
		tp0_s4    <= tp0_s3;
		tp1_s4    <= tp1_s3;
		tp2_s4    <= tp2_s3;

		jint_s5   <= jint_s4;
		rem_s5    <= rsum[SynW:0];
		tp0_s5    <= tp0_s4;
		tp1_s5    <= tp1_s4;
		tp2_s5    <= tp2_s4;

		jint_s6   <= jint_s5;
		sint_s6   <= span[FRAC_BITS +: 5];

		// the half day of the 0h start cancels against the rounding half day
		z_s7      <= jint_s6 + JW'(sint_s6);
	end

	always_comb begin
		zd.valid = v_s7;
		zd.z     = z_s7;
	end

	nlpd_cal u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.zin    (zd),
		.done   (done),
		.result (result)
	);

endmodule

>>> sim/next_lunar_phase_date_core_tb.sv
// Self-checking testbench for the next lunar phase date pipeline.
`timescale 1ns / 100ps

module next_lunar_phase_date_core_tb;

	localparam int FRAC = 32;
	localparam int TAIL_CYCLES = 30;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	nlpd_pkg::req_t    req;
	logic              done;
	nlpd_pkg::result_t result;

	nlpd_pkg::result_t expected_dates[$];
	longint  syn_fx;
	longint  epoch_fx;
	int      requests_sent;
	int      results_checked;
	int      mismatches;

	next_lunar_phase_date_core #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result)
	);

	always #2 clk = ~clk;

	// round(num * 2^FRAC / den)
	function automatic longint unsigned fixed_ratio(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = num / den;
		r = num % den;
		for (int i = 0; i < FRAC + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && (a % b) < 0)
			q = q - 1;
		return q;
	endfunction

	// Julian day of the start date at 0h, fixed point; input read as Gregorian
	function automatic longint start_jd(nlpd_pkg::req_t r);
		longint y;
		longint m;
		longint d;
		longint b;
		longint jint;
		y = r.in_year;
		m = r.in_month;
		d = r.in_day;
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (m <= 2) begin
			y = y - 1;
			m = m + 12;
		end
		b = 2 - floor_quot(y, 100) + floor_quot(y, 400);
		jint = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + d + b - 1524;
		return jint * (longint'(1) << FRAC) - (longint'(1) << (FRAC - 1));
	endfunction

	// Mean phase of a day instant as a remainder in [0, SYN)
	function automatic longint phase_offset(longint jd);
		longint diff;
		longint n;
		diff = jd - epoch_fx;
		n = floor_quot(diff, syn_fx);
		return diff - n * syn_fx;
	endfunction

	// Largest goal whose offset does not pass the current phase of the date
	function automatic logic [15:0] goal_at_phase(nlpd_pkg::req_t r);
		longint rem;
		rem = phase_offset(start_jd(r));
		return 16'((rem << 16) / syn_fx);
	endfunction

	function automatic nlpd_pkg::result_t predict_phase_date(nlpd_pkg::req_t r);
		longint jd;
		longint target;
		longint span;
		longint z;
		longint a;
		longint alpha;
		longint bb;
		longint c;
		longint dd;
		longint e;
		longint day;
		longint month;
		longint year;
		nlpd_pkg::result_t res;
		jd = start_jd(r);
		target = (longint'(r.phase_goal) * syn_fx) >> 16;
		span = target - phase_offset(jd);
		// the target already reached or passed: wait for next month
		if (span <= 0)
			span = span + syn_fx;
		jd = jd + span + (longint'(1) << (FRAC - 1));
		z = jd / (longint'(1) << FRAC);
		if (z < 2299161) begin
			a = z;
		end else begin
			alpha = (4 * z - 7468865) / 146097;
			a = z + 1 + alpha - alpha / 4;
		end
		bb = a + 1524;
		c = (20 * bb - 2442) / 7305;
		dd = (1461 * c) / 4;
		e = (10000 * (bb - dd)) / 306001;
		day = bb - dd - (306001 * e) / 10000;
		month = (e < 14) ? e - 1 : e - 13;
		year = (month > 2) ? c - 4716 : c - 4715;
		res.event_year = year[12:0];
		res.event_month = month[3:0];
		res.event_day = day[4:0];
		return res;
	endfunction

	function automatic nlpd_pkg::req_t date_req(int y, int m, int d, int g);
		nlpd_pkg::req_t r;
		r.in_year = y[11:0];
		r.in_month = m[3:0];
		r.in_day = d[4:0];
		r.phase_goal = g[15:0];
		return r;
	endfunction

	// Present one request and hold it until taken
	task automatic send_req(nlpd_pkg::req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_dates.push_back(predict_phase_date(r));
		requests_sent++;
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold off new requests until every pending result is back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_dates.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		nlpd_pkg::result_t want;
		if (arst_n && done) begin
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d-%0d-%0d", $time,
					result.event_year, result.event_month, result.event_day);
				mismatches++;
			end else begin
				want = expected_dates.pop_front();
				report_field("event_year", want.event_year, result.event_year);
				report_field("event_month", want.event_month, result.event_month);
				report_field("event_day", want.event_day, result.event_day);
				results_checked++;
			end
		end
	end

	task automatic test_calendar_extremes();
		send_req(date_req(1, 1, 1, 0));
		send_req(date_req(4095, 12, 31, 65535));
		send_req(date_req(0, 1, 1, 0));
		send_req(date_req(0, 3, 1, 32768));
		// start days straddling the epoch
		send_req(date_req(2000, 1, 6, 0));
		send_req(date_req(2000, 1, 6, 32768));
		send_req(date_req(2000, 1, 6, 65535));
		drain_results();
	endtask

	task automatic test_out_of_range_fields();
		send_req(date_req(2023, 0, 15, 1000));
		send_req(date_req(2023, 13, 15, 2000));
		idle_cycles(3);
		send_req(date_req(2023, 15, 31, 40000));
		send_req(date_req(2024, 2, 0, 12345));
		send_req(date_req(2024, 2, 31, 54321));
		send_req(date_req(2023, 4, 31, 16384));
		drain_results();
	endtask

	task automatic test_calendar_switch();
		send_req(date_req(1582, 10, 4, 0));
		send_req(date_req(1582, 10, 15, 32768));
		send_req(date_req(1582, 10, 10, 20000));
		send_req(date_req(1000, 6, 15, 49152));
		send_req(date_req(1, 3, 1, 65535));
		drain_results();
	endtask

	// Goals just at and just past the current phase: a full month or a small step
	task automatic test_phase_edges();
		nlpd_pkg::req_t r;
		logic [15:0] g;
		r = date_req(2024, 7, 14, 0);
		g = goal_at_phase(r);
		r.phase_goal = g;
		send_req(r);
		r.phase_goal = (g == 16'hFFFF) ? g : g + 16'd1;
		send_req(r);
		r = date_req(1850, 2, 28, 0);
		g = goal_at_phase(r);
		r.phase_goal = g;
		send_req(r);
		r.phase_goal = (g == 16'hFFFF) ? g : g + 16'd1;
		send_req(r);
		drain_results();
	endtask

	task automatic test_random_dates(int count);
		int left;
		int burst;
		int kind;
		nlpd_pkg::req_t r;
		logic [15:0] g;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 32);
			while (burst > 0 && left > 0) begin
				kind = $urandom_range(0, 99);
				r.in_year = 12'($urandom_range(0, 4095));
				r.in_month = 4'($urandom_range(1, 12));
				r.in_day = 5'($urandom_range(1, 28));
				r.phase_goal = 16'($urandom);
				if (kind < 60) begin
					// well-formed date, random goal
				end else if (kind < 75) begin
					g = goal_at_phase(r);
					if ($urandom_range(0, 1) && g != 16'hFFFF)
						g = g + 16'd1;
					r.phase_goal = g;
				end else if (kind < 85) begin
					r.in_year = 12'($urandom_range(0, 1600));
				end else begin
					r.in_month = 4'($urandom_range(0, 15));
					r.in_day = 5'($urandom_range(0, 31));
				end
				send_req(r);
				burst--;
				left--;
			end
			case ($urandom_range(0, 7))
				0: drain_results();
				1, 2: ;
				default: idle_cycles($urandom_range(1, 12));
			endcase
		end
		drain_results();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		requests_sent = 0;
		results_checked = 0;
		mismatches = 0;
		syn_fx = longint'(fixed_ratio(64'd29530588861, 64'd1000000000));
		epoch_fx = longint'(fixed_ratio(64'd24515501, 64'd10));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_calendar_extremes();
		test_out_of_range_fields();
		test_calendar_switch();
		test_phase_edges();
		test_random_dates(880);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests: calendar extremes, out-of-range months and days,",
			requests_sent);
		$display("calendar switch, phase edges and random dates; %0d results, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0 && expected_dates.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", expected_dates.size());
		$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
hdl/nlpd_pkg.sv
hdl/nlpd_cal.sv
hdl/next_lunar_phase_date_core.sv
sim/next_lunar_phase_date_core_tb.sv
